FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the float literal scanner.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FLS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define FLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define FLS_ASSERT_ALWAYS(label, clk, rst_n, expr)

`define FLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/fls_pkg.sv
// Types, constants and helpers of the float literal scanner.
// No dependencies; used by fls_scan, fls_queue and float_literal_scanner.
package fls_pkg;

    localparam int MAX_DIGITS = 63;
    localparam int KEPT_W     = $clog2(MAX_DIGITS + 1);
    localparam int EXP_W      = 33;
    localparam int SUM_W      = EXP_W + 2;

    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int RES_W      = QCNT_W + 1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOWER = 8'h20;

    localparam logic signed [EXP_W-1:0] SHIFT_MAX = {1'b0, {(EXP_W-1){1'b1}}};
    localparam logic signed [EXP_W-1:0] SHIFT_MIN = {1'b1, {(EXP_W-1){1'b0}}};
    localparam logic [EXP_W-1:0]        ACC_MAX   = {EXP_W{1'b1}};

    localparam logic [1:0] FMT_NONE    = 2'd3;
    localparam logic [1:0] PREC_SINGLE = 2'd0;
    localparam logic [1:0] PREC_DOUBLE = 2'd1;
    localparam logic [1:0] PREC_LONG   = 2'd2;

    localparam logic KIND_DIGIT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_INT        = 3'd1,
        PH_FRACT      = 3'd2,
        PH_EXP_START  = 3'd3,
        PH_EXP_SIGNED = 3'd4,
        PH_EXP_DIGITS = 3'd5,
        PH_DONE       = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        LET_E = 3'd0,
        LET_F = 3'd1,
        LET_D = 3'd2,
        LET_L = 3'd3,
        LET_S = 3'd4
    } letter_t;

    typedef struct packed {
        logic    hit;
        letter_t code;
    } letter_hit_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
    } item_t;

    // One scanned item: an optional digit and an optional raw summary.
    typedef struct packed {
        logic                     has_digit;
        logic                     has_sum;
        logic [3:0]               digit;
        logic                     negative;
        logic                     nonzero;
        logic                     err_pre;
        logic [1:0]               prec;
        logic                     exp_neg;
        logic [EXP_W-1:0]         acc;
        logic signed [EXP_W-1:0]  shift;
    } scan_rec_t;

    typedef struct packed {
        logic               kind;
        logic [3:0]         digit;
        logic               negative;
        logic signed [31:0] dec_exponent;
        logic [1:0]         precision;
        logic               is_zero;
        logic               syntax_error;
        logic               end_of_token;
    } result_t;

    function automatic letter_hit_t letter_decode(input logic [7:0] ch);
        letter_hit_t r;
        logic [7:0]  lc;
        lc     = ch | CH_LOWER;
        r.hit  = 1'b1;
        r.code = LET_E;
        if (lc == 8'h65)      r.code = LET_E;
        else if (lc == 8'h66) r.code = LET_F;
        else if (lc == 8'h64) r.code = LET_D;
        else if (lc == 8'h6C) r.code = LET_L;
        else if (lc == 8'h73) r.code = LET_S;
        else                  r.hit  = 1'b0;
        return r;
    endfunction

endpackage

FILE: hw/rtl/float_literal_scanner.sv
// Decimal float literal scanner, top level: ports, input and config registers.
// Depends on fls_pkg, fls_scan, fls_queue and assert_macros.svh.
//
// Usage: characters of a token enter on the input channel (ch, last) with
// in_valid/in_stall, one per cycle. Each significant mantissa digit yields a
// digit item (kind 0); the end of a token (ch zero or last set) yields a
// summary item (kind 1, end_of_token 1) with sign, exponent, precision and
// flags. Results leave on out_valid/out_stall, in input order.
// default_format is written through cfg_valid/cfg_ready/cfg_data while idle;
// cfg_ready is always high.
// A result passes the input register, the scan register and the result
// queue before it can be taken.
// Throughput: one character per cycle while in_stall is low; one output item
// per cycle while out_stall is low, so a character that both adds a digit and
// ends a token yields two output items. The 8-entry result queue sets in_stall
// when fewer than two free slots remain beyond the items in flight.
// Reset clears the token state, the queue and default_format (single).
// While out_stall is high the head item holds and the queue fills; input is
// then stalled and nothing is lost.
`include "assert_macros.svh"

module float_literal_scanner (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [3:0]         digit,
    output logic               negative,
    output logic signed [31:0] dec_exponent,
    output logic [1:0]         precision,
    output logic               is_zero,
    output logic               syntax_error,
    output logic               end_of_token,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);

    fls_pkg::item_t                     item_reg, item_next;
    logic [1:0]                         fmt_reg, fmt_next;
    fls_pkg::scan_rec_t                 rec;
    fls_pkg::result_t                   head;
    logic [fls_pkg::QCNT_W-1:0]         q_count;
    logic [fls_pkg::RES_W-1:0]          reserve;

    assign cfg_ready = 1'b1;
    assign fmt_next  = (cfg_valid && cfg_ready) ? cfg_data : fmt_reg;

    // queue slots claimed by the queue and by items still in flight
    assign reserve  = fls_pkg::RES_W'(q_count)
                    + (item_reg.valid ? fls_pkg::RES_W'(2) : '0)
                    + fls_pkg::RES_W'(rec.has_digit) + fls_pkg::RES_W'(rec.has_sum);
    assign in_stall = (reserve > fls_pkg::RES_W'(fls_pkg::QDEPTH - 2));

    always_comb
    begin
        item_next.valid = in_valid && !in_stall;
        item_next.ch    = ch;
        item_next.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
            fmt_reg  <= '0;
        end
        else
        begin
            item_reg <= item_next;
            fmt_reg  <= fmt_next;
        end
    end

    fls_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_reg),
        .default_format (fmt_reg),
        .rec            (rec)
    );

    fls_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rec),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .count     (q_count)
    );

    assign kind         = head.kind;
    assign digit        = head.digit;
    assign negative     = head.negative;
    assign dec_exponent = head.dec_exponent;
    assign precision    = head.precision;
    assign is_zero      = head.is_zero;
    assign syntax_error = head.syntax_error;
    assign end_of_token = head.end_of_token;

    `FLS_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_count <= fls_pkg::QCNT_W'(fls_pkg::QDEPTH))
    `FLS_ASSERT_IMPLIES(a_summary_ends, clk, rst_n, out_valid && kind, end_of_token)
    `FLS_ASSERT_IMPLIES(a_digit_item, clk, rst_n, out_valid && !kind, (digit <= 4'd9) && !end_of_token && !syntax_error)
    `FLS_ASSERT_IMPLIES(a_error_clean, clk, rst_n, out_valid && syntax_error, (dec_exponent == 32'sd0) && (precision == 2'd0) && !is_zero)

endmodule

FILE: hw/rtl/fls_scan.sv
// Character scanner: token state machine and the scan record register.
// Depends on fls_pkg.
module fls_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  fls_pkg::item_t    item,
    input  logic [1:0]        default_format,
    output fls_pkg::scan_rec_t rec
);

    fls_pkg::phase_t                       phase_reg, phase_next;
    logic                                  sign_reg, sign_next;
    logic                                  nz_reg, nz_next;
    logic [fls_pkg::KEPT_W-1:0]            kept_reg, kept_next;
    logic signed [fls_pkg::EXP_W-1:0]      shift_reg, shift_next;
    logic                                  eneg_reg, eneg_next;
    logic [fls_pkg::EXP_W-1:0]             acc_reg, acc_next;
    fls_pkg::letter_t                      letter_reg, letter_next;
    logic                                  failed_reg, failed_next;
    fls_pkg::scan_rec_t                    rec_reg, rec_next;

    logic                                  is_dec;
    fls_pkg::letter_hit_t                  lt;
    logic [fls_pkg::EXP_W+3:0]             acc_wide;
    logic [fls_pkg::EXP_W-1:0]             acc_sat;
    logic                                  run_int, run_exp, keep, try_let;
    logic                                  shift_up, shift_dn;

    assign is_dec   = (item.ch >= fls_pkg::CH_ZERO) && (item.ch <= fls_pkg::CH_NINE);
    assign lt       = fls_pkg::letter_decode(item.ch);
    // acc * 10 + d, saturating
    assign acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {{fls_pkg::EXP_W{1'b0}}, item.ch[3:0]};
    assign acc_sat  = (|acc_wide[fls_pkg::EXP_W+3:fls_pkg::EXP_W]) ? fls_pkg::ACC_MAX
                    : acc_wide[fls_pkg::EXP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fls_pkg::PH_START;
            sign_reg   <= 1'b0;
            nz_reg     <= 1'b0;
            kept_reg   <= '0;
            shift_reg  <= '0;
            eneg_reg   <= 1'b0;
            acc_reg    <= '0;
            letter_reg <= fls_pkg::LET_E;
            failed_reg <= 1'b0;
            rec_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sign_reg   <= sign_next;
            nz_reg     <= nz_next;
            kept_reg   <= kept_next;
            shift_reg  <= shift_next;
            eneg_reg   <= eneg_next;
            acc_reg    <= acc_next;
            letter_reg <= letter_next;
            failed_reg <= failed_next;
            rec_reg    <= rec_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        sign_next   = sign_reg;
        nz_next     = nz_reg;
        kept_next   = kept_reg;
        shift_next  = shift_reg;
        eneg_next   = eneg_reg;
        acc_next    = acc_reg;
        letter_next = letter_reg;
        failed_next = failed_reg;
        rec_next    = '0;
        run_int     = 1'b0;
        run_exp     = 1'b0;
        keep        = 1'b0;
        try_let     = 1'b0;
        shift_up    = 1'b0;
        shift_dn    = 1'b0;

        if (item.valid && (phase_reg != fls_pkg::PH_DONE))
        begin
            if ((item.ch != fls_pkg::CH_NUL) && !failed_reg)
            begin
                unique case (phase_reg)
                    fls_pkg::PH_START:
                    begin
                        phase_next = fls_pkg::PH_INT;
                        if (item.ch == fls_pkg::CH_PLUS)
                        begin
                        end
                        else if (item.ch == fls_pkg::CH_MINUS)
                            sign_next = 1'b1;
                        else
                            run_int = 1'b1;
                    end
                    fls_pkg::PH_INT:
                        run_int = 1'b1;
                    fls_pkg::PH_FRACT:
                    begin
                        if (is_dec)
                        begin
                            if (!nz_reg)
                            begin
                                shift_dn = 1'b1;
                                if (item.ch != fls_pkg::CH_ZERO)
                                begin
                                    nz_next = 1'b1;
                                    keep    = 1'b1;
                                end
                            end
                            else
                                keep = 1'b1;
                        end
                        else
                            try_let = 1'b1;
                    end
                    fls_pkg::PH_EXP_START:
                    begin
                        if (item.ch == fls_pkg::CH_PLUS)
                            phase_next = fls_pkg::PH_EXP_SIGNED;
                        else if (item.ch == fls_pkg::CH_MINUS)
                        begin
                            eneg_next  = 1'b1;
                            phase_next = fls_pkg::PH_EXP_SIGNED;
                        end
                        else
                            run_exp = 1'b1;
                    end
                    fls_pkg::PH_EXP_SIGNED, fls_pkg::PH_EXP_DIGITS:
                        run_exp = 1'b1;
                    default:
                    begin
                    end
                endcase

                if (run_int)
                begin
                    if (!nz_reg && (item.ch == fls_pkg::CH_ZERO))
                    begin
                    end
                    else if (is_dec)
                    begin
                        shift_up = nz_reg;
                        nz_next  = 1'b1;
                        keep     = 1'b1;
                    end
                    else if (item.ch == fls_pkg::CH_DOT)
                        phase_next = fls_pkg::PH_FRACT;
                    else
                        try_let = 1'b1;
                end

                if (try_let)
                begin
                    if (lt.hit)
                    begin
                        letter_next = lt.code;
                        phase_next  = fls_pkg::PH_EXP_START;
                    end
                    else
                        failed_next = 1'b1;
                end

                if (run_exp)
                begin
                    if (is_dec)
                    begin
                        acc_next   = acc_sat;
                        phase_next = fls_pkg::PH_EXP_DIGITS;
                    end
                    else
                        failed_next = 1'b1;
                end

                if (keep && (kept_reg < fls_pkg::KEPT_W'(fls_pkg::MAX_DIGITS)))
                begin
                    kept_next          = kept_reg + 1'b1;
                    rec_next.has_digit = 1'b1;
                    rec_next.digit     = item.ch[3:0];
                end

                if (shift_up && (shift_reg != fls_pkg::SHIFT_MAX))
                    shift_next = shift_reg + 1'b1;
                if (shift_dn && (shift_reg != fls_pkg::SHIFT_MIN))
                    shift_next = shift_reg - 1'b1;
            end

            if ((item.ch == fls_pkg::CH_NUL) || item.last)
            begin
                rec_next.has_sum  = 1'b1;
                rec_next.negative = sign_next;
                rec_next.nonzero  = nz_next;
                rec_next.exp_neg  = eneg_next;
                rec_next.acc      = acc_next;
                rec_next.shift    = shift_next;
                rec_next.err_pre  = failed_next;
                unique case (letter_next)
                    fls_pkg::LET_E:
                    begin
                        if (default_format == fls_pkg::FMT_NONE)
                            rec_next.err_pre = 1'b1;
                        else
                            rec_next.prec = default_format;
                    end
                    fls_pkg::LET_D: rec_next.prec = fls_pkg::PREC_DOUBLE;
                    fls_pkg::LET_L: rec_next.prec = fls_pkg::PREC_LONG;
                    default:        rec_next.prec = fls_pkg::PREC_SINGLE;
                endcase

                phase_next  = item.last ? fls_pkg::PH_START : fls_pkg::PH_DONE;
                sign_next   = 1'b0;
                nz_next     = 1'b0;
                kept_next   = '0;
                shift_next  = '0;
                eneg_next   = 1'b0;
                acc_next    = '0;
                letter_next = fls_pkg::LET_E;
                failed_next = 1'b0;
            end
        end
        else if (item.valid && item.last)
            phase_next = fls_pkg::PH_START;
    end

    assign rec = rec_reg;

endmodule

FILE: hw/rtl/fls_queue.sv
// Summary exponent arithmetic and the result queue that feeds the output.
// Depends on fls_pkg.
module fls_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fls_pkg::scan_rec_t          rec,
    input  logic                        out_stall,
    output logic                        out_valid,
    output fls_pkg::result_t            head,
    output logic [fls_pkg::QCNT_W-1:0]  count
);

    fls_pkg::result_t                  q_mem [fls_pkg::QDEPTH];
    logic [fls_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [fls_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [fls_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic [fls_pkg::QPTR_W-1:0]        sum_ptr;

    logic signed [fls_pkg::SUM_W-1:0]  shift_ext, acc_ext, exp_sum;
    logic                              out_of_range, err;
    fls_pkg::result_t                  dig_res, sum_res;
    logic                              pop;

    assign shift_ext = {{2{rec.shift[fls_pkg::EXP_W-1]}}, rec.shift};
    assign acc_ext   = {2'b00, rec.acc};
    assign exp_sum   = rec.exp_neg ? (shift_ext - acc_ext) : (shift_ext + acc_ext);
    assign out_of_range = !((&exp_sum[fls_pkg::SUM_W-1:31]) || !(|exp_sum[fls_pkg::SUM_W-1:31]));
    assign err       = rec.err_pre || (rec.nonzero && out_of_range);

    always_comb
    begin
        dig_res       = '0;
        dig_res.kind  = fls_pkg::KIND_DIGIT;
        dig_res.digit = rec.digit;

        sum_res              = '0;
        sum_res.kind         = fls_pkg::KIND_SUMMARY;
        sum_res.negative     = rec.negative;
        sum_res.dec_exponent = (err || !rec.nonzero) ? '0 : exp_sum[31:0];
        sum_res.precision    = err ? fls_pkg::PREC_SINGLE : rec.prec;
        sum_res.is_zero      = !err && !rec.nonzero;
        sum_res.syntax_error = err;
        sum_res.end_of_token = 1'b1;
    end

    assign pop         = out_valid && !out_stall;
    assign sum_ptr     = wr_ptr_reg + fls_pkg::QPTR_W'(rec.has_digit);
    assign wr_ptr_next = wr_ptr_reg + fls_pkg::QPTR_W'(rec.has_digit)
                       + fls_pkg::QPTR_W'(rec.has_sum);
    assign rd_ptr_next = rd_ptr_reg + fls_pkg::QPTR_W'(pop);
    assign count_next  = count_reg + fls_pkg::QCNT_W'(rec.has_digit)
                       + fls_pkg::QCNT_W'(rec.has_sum) - fls_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (rec.has_digit)
            q_mem[wr_ptr_reg] <= dig_res;
        if (rec.has_sum)
            q_mem[sum_ptr] <= sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign head      = q_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: tb/float_literal_scanner_checker.sv
// Checker for float_literal_scanner: tracks the token state from accepted items,
// predicts digit and summary results and compares them in order.
// Depends on fls_pkg.
module float_literal_scanner_checker
    import fls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               kind,
    input  logic [3:0]         digit,
    input  logic               negative,
    input  logic signed [31:0] dec_exponent,
    input  logic [1:0]         precision,
    input  logic               is_zero,
    input  logic               syntax_error,
    input  logic               end_of_token,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    output int                 fail_count,
    output int                 outstanding
);

    localparam longint SHIFT_TOP = 64'sd4294967295;
    localparam longint SHIFT_BOT = -64'sd4294967296;
    localparam longint ACC_TOP   = 64'sd8589934591;
    localparam longint EXP_TOP   = 64'sd2147483647;
    localparam longint EXP_BOT   = -64'sd2147483648;

    logic [1:0] fmt;
    phase_t     phase;
    letter_t    letter;
    bit         sign_seen;
    bit         nonzero_seen;
    bit         exp_neg;
    bit         failed;
    int         kept;
    longint     shift;
    longint     acc;

    result_t lexer_out_q[$];
    int      n_fail = 0;
    int      n_pending = 0;

    assign fail_count  = n_fail;
    assign outstanding = n_pending;

    function void clear_token();
        phase        = PH_START;
        letter       = LET_E;
        sign_seen    = 1'b0;
        nonzero_seen = 1'b0;
        exp_neg      = 1'b0;
        failed       = 1'b0;
        kept         = 0;
        shift        = 0;
        acc          = 0;
    endfunction

    function bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void bump_shift(longint d);
        longint v;
        v = shift + d;
        if (v > SHIFT_TOP) v = SHIFT_TOP;
        if (v < SHIFT_BOT) v = SHIFT_BOT;
        shift = v;
    endfunction

    function bit keep_digit();
        if (kept < MAX_DIGITS) begin
            kept++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void take_letter(logic [7:0] c);
        case (c | CH_LOWER)
            "e": letter = LET_E;
            "f": letter = LET_F;
            "d": letter = LET_D;
            "l": letter = LET_L;
            "s": letter = LET_S;
            default:
            begin
                failed = 1'b1;
                return;
            end
        endcase
        phase = PH_EXP_START;
    endfunction

    // Returns 1 when the character yields a mantissa digit.
    function bit scan_character(logic [7:0] c);
        longint d;
        if (failed)
            return 1'b0;
        if (phase == PH_START)
        begin
            phase = PH_INT;
            if (c == CH_PLUS)
                return 1'b0;
            if (c == CH_MINUS)
            begin
                sign_seen = 1'b1;
                return 1'b0;
            end
        end
        case (phase)
            PH_INT:
            begin
                if (!nonzero_seen && c == CH_ZERO)
                    return 1'b0;
                if (is_digit(c))
                begin
                    if (nonzero_seen)
                        bump_shift(1);
                    nonzero_seen = 1'b1;
                    return keep_digit();
                end
                if (c == CH_DOT)
                    phase = PH_FRACT;
                else
                    take_letter(c);
                return 1'b0;
            end
            PH_FRACT:
            begin
                if (is_digit(c))
                begin
                    if (!nonzero_seen)
                    begin
                        bump_shift(-1);
                        if (c == CH_ZERO)
                            return 1'b0;
                        nonzero_seen = 1'b1;
                    end
                    return keep_digit();
                end
                take_letter(c);
                return 1'b0;
            end
            PH_EXP_START, PH_EXP_SIGNED, PH_EXP_DIGITS:
            begin
                if (phase == PH_EXP_START && (c == CH_PLUS || c == CH_MINUS))
                begin
                    exp_neg = (c == CH_MINUS);
                    phase   = PH_EXP_SIGNED;
                    return 1'b0;
                end
                if (is_digit(c))
                begin
                    d = longint'(c - CH_ZERO);
                    if (acc > (ACC_TOP - d) / 10)
                        acc = ACC_TOP;
                    else
                        acc = acc * 10 + d;
                    phase = PH_EXP_DIGITS;
                end
                else
                    failed = 1'b1;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function result_t token_summary();
        result_t    r;
        bit         err;
        logic [1:0] prec;
        longint     e;
        err  = failed;
        prec = PREC_SINGLE;
        e    = 0;
        case (letter)
            LET_E:
            begin
                if (fmt == FMT_NONE)
                    err = 1'b1;
                else
                    prec = fmt;
            end
            LET_D:   prec = PREC_DOUBLE;
            LET_L:   prec = PREC_LONG;
            default: prec = PREC_SINGLE;
        endcase
        if (!err && nonzero_seen)
        begin
            e = (exp_neg ? -acc : acc) + shift;
            if (e > EXP_TOP || e < EXP_BOT)
                err = 1'b1;
        end
        r              = '0;
        r.kind         = KIND_SUMMARY;
        r.negative     = sign_seen;
        r.dec_exponent = err ? 32'sd0 : e[31:0];
        r.precision    = err ? PREC_SINGLE : prec;
        r.is_zero      = !err && !nonzero_seen;
        r.syntax_error = err;
        r.end_of_token = 1'b1;
        return r;
    endfunction

    function void lex_item(logic [7:0] c, logic is_last);
        result_t r;
        if (phase == PH_DONE)
        begin
            if (is_last)
                clear_token();
            return;
        end
        if (c != CH_NUL)
        begin
            if (scan_character(c))
            begin
                r       = '0;
                r.kind  = KIND_DIGIT;
                r.digit = 4'(c - CH_ZERO);
                lexer_out_q.push_back(r);
            end
        end
        if (c == CH_NUL || is_last)
        begin
            lexer_out_q.push_back(token_summary());
            clear_token();
            if (!is_last)
                phase = PH_DONE;
        end
    endfunction

    function void compare(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fmt = PREC_SINGLE;
            clear_token();
            lexer_out_q.delete();
            n_pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (lexer_out_q.size() == 0)
                begin
                    $error("unexpected result item: kind %0d digit %0d", kind, digit);
                    n_fail++;
                end
                else
                begin
                    want = lexer_out_q.pop_front();
                    compare("kind", want.kind, kind);
                    compare("digit", want.digit, digit);
                    compare("negative", want.negative, negative);
                    compare("dec_exponent", longint'($signed(want.dec_exponent)),
                            longint'(dec_exponent));
                    compare("precision", want.precision, precision);
                    compare("is_zero", want.is_zero, is_zero);
                    compare("syntax_error", want.syntax_error, syntax_error);
                    compare("end_of_token", want.end_of_token, end_of_token);
                end
            end
            if (cfg_valid && cfg_ready)
                fmt = cfg_data;
            if (in_valid && !in_stall)
                lex_item(ch, last);
            n_pending = lexer_out_q.size();
        end
    end

endmodule

FILE: tb/float_literal_scanner_tb.sv
// Testbench top for float_literal_scanner: drives tokens with bursty input and
// random output stalls, writes default_format between phases, reports the verdict.
// Depends on fls_pkg, float_literal_scanner and float_literal_scanner_checker.
module float_literal_scanner_tb;
    import fls_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASES       = 6;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         ch;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic               kind;
    logic [3:0]         digit;
    logic               negative;
    logic signed [31:0] dec_exponent;
    logic [1:0]         precision;
    logic               is_zero;
    logic               syntax_error;
    logic               end_of_token;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_data;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int sent = 0;
    int burst_left = 0;
    bit sender_idles = 1'b1;

    logic [8:0] token_q[$];

    float_literal_scanner u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .digit        (digit),
        .negative     (negative),
        .dec_exponent (dec_exponent),
        .precision    (precision),
        .is_zero      (is_zero),
        .syntax_error (syntax_error),
        .end_of_token (end_of_token),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    float_literal_scanner_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .digit        (digit),
        .negative     (negative),
        .dec_exponent (dec_exponent),
        .precision    (precision),
        .is_zero      (is_zero),
        .syntax_error (syntax_error),
        .end_of_token (end_of_token),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function void put_char(logic [7:0] c);
        token_q.push_back({1'b0, c});
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function void put_digits(int n);
        repeat (n)
            put_char(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function void put_sign();
        case ($urandom_range(0, 2))
            1:       put_char(CH_PLUS);
            2:       put_char(CH_MINUS);
            default: ;
        endcase
    endfunction

    // Well-formed literal: sign, integer part, fraction, exponent.
    function void build_literal(bit long_mant);
        string  letters;
        longint big;
        letters = "eEfFdDlLsS";
        put_sign();
        repeat ($urandom_range(0, 2))
            put_char(CH_ZERO);
        put_digits(long_mant ? $urandom_range(40, 75) : $urandom_range(0, 4));
        if ($urandom_range(0, 2) != 0)
        begin
            put_char(CH_DOT);
            repeat ($urandom_range(0, 3))
                put_char(CH_ZERO);
            put_digits((long_mant && $urandom_range(0, 1)) ? $urandom_range(30, 70)
                                                           : $urandom_range(0, 4));
        end
        if ($urandom_range(0, 9) < 7)
        begin
            put_char(letters[$urandom_range(0, 9)]);
            put_sign();
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       big = 64'd2147483647 - $urandom_range(0, 80);
                    1:       big = 64'd2147483648 + $urandom_range(0, 80);
                    2:       big = 64'd99999999999;
                    default: big = 64'd4294967296 + $urandom_range(0, 9);
                endcase
                put_text($sformatf("%0d", big));
            end
            else
                put_digits($urandom_range(0, 3));
        end
    endfunction

    task automatic send_item(input logic [8:0] it);
        int gap;
        if (sender_idles && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                ch       <= 8'($urandom);
                last     <= 1'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        ch       <= it[7:0];
        last     <= it[8];
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_token();
        if (token_q.size() == 0)
            put_char(CH_ZERO);
        token_q[token_q.size() - 1][8] = 1'b1;
        foreach (token_q[i])
            send_item(token_q[i]);
        token_q.delete();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    task automatic write_format(input logic [1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stall patterns per segment, with a long hold every fifth one.
    initial
    begin
        int seg;
        int mode;
        int span;
        out_stall = 1'b0;
        seg = 0;
        forever
        begin
            if (seg % 5 == 3)
            begin
                span = $urandom_range(40, 90);
                for (int i = 0; i < span; i++)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                mode = $urandom_range(0, 4);
                span = $urandom_range(20, 150);
                for (int i = 0; i < span; i++)
                begin
                    @(negedge clk);
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 9) < 7);
                        3:       out_stall <= (i % 4 < 2);
                        default: out_stall <= (i % 7 == 0);
                    endcase
                end
            end
            seg++;
        end
    end

    initial
    begin
        int         pick;
        int         target;
        logic [1:0] fmt;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        ch        = CH_NUL;
        last      = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = PREC_SINGLE;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed tokens under the reset format
        put_text("0");
        send_token();
        put_text("-1.5d-3");
        send_token();
        put_text("+.07L9");
        send_token();
        put_text("x");
        send_token();
        put_text("2s");
        send_token();
        put_text("3F");
        send_token();
        put_text("1");
        put_char(CH_NUL);
        put_char(8'hFF);
        send_token();
        put_char(CH_NUL);
        send_token();

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            repeat (8) @(posedge clk);
            case (p)
                0:       fmt = FMT_NONE;
                1:       fmt = PREC_DOUBLE;
                2:       fmt = PREC_LONG;
                3:       fmt = PREC_SINGLE;
                4:       fmt = FMT_NONE;
                default: fmt = 2'($urandom_range(0, 3));
            endcase
            write_format(fmt);
            sender_idles = (p != 2);
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    build_literal($urandom_range(0, 19) == 0);
                else if (pick < 75)
                begin
                    build_literal(1'b0);
                    put_char(CH_NUL);
                    repeat ($urandom_range(0, 4))
                        put_char(8'($urandom_range(0, 255)));
                end
                else if (pick < 87)
                begin
                    build_literal(1'b0);
                    if (token_q.size() > 0 && $urandom_range(0, 1))
                        token_q[$urandom_range(0, token_q.size() - 1)] =
                            {1'b0, 8'($urandom_range(1, 255))};
                    else
                        token_q.insert($urandom_range(0, token_q.size()),
                                       {1'b0, 8'($urandom_range(1, 255))});
                end
                else
                begin
                    repeat ($urandom_range(1, 5))
                        put_char(8'($urandom_range(0, 255)));
                end
                send_token();
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
